// ----- src/indexed_circular_deque_unit_macros.svh -----
// Assertion macros for the indexed circular deque unit.
`ifndef INDEXED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define INDEXED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ICD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("indexed circular deque: assertion failed");
`define ICD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("indexed circular deque: assertion failed");
`else
`define ICD_ASSERT(lbl, clk, rst_n, prop)
`define ICD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/icd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package icd_pkg;

	localparam int OPCODE_W   = 2;
	localparam int POSITION_W = 7;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	localparam logic [OPCODE_W-1:0] OP_GET    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SET    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0]   opcode;
		logic [POSITION_W-1:0] position;
		logic [VALUE_W-1:0]    value_in;
	} cmd_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value_out;
		logic [COUNT_W-1:0]  item_count;
		logic [STATUS_W-1:0] status;
	} rsp_word_t;

endpackage

`default_nettype wire

// ----- src/icd_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface icd_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- src/indexed_circular_deque_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Indexed list of up to CAPACITY words held in a circular single-port-per-direction store,
// addressed through a head slot and an element count; one word is processed at a time.
// A flagged word goes from the check straight to its result, and a get or a set reads or
// writes its slot; an insert or a remove moves elements and then updates the count, where
// the shorter side of the list is moved, so at most about CAPACITY/2 elements. The next
// word is taken from the cycle after the result has been loaded.
// The move rate of one element per cycle is set by the store's
// one read and one write port, pipelined so that each read feeds the next cycle's write.
// The store needs no clearing after reset, so words are taken as soon as reset ends.
`include "indexed_circular_deque_unit_macros.svh"

module indexed_circular_deque_unit #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	icd_chan_if.sink   cmd,
	icd_chan_if.source rsp
);

	import icd_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int SW   = CW + 1;
	localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_MOVE   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] l);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(l);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return s[IW-1:0];
	endfunction

	logic [2:0]            state_q;
	logic [OPCODE_W-1:0]   op_q;
	logic [POSITION_W-1:0] pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [IW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         n_q;
	logic                  up_q;
	logic                  front_q;
	logic                  wr_pend_s1;
	logic [IW-1:0]         wr_addr_s1;
	logic [DATA_WIDTH-1:0] rval_q;
	logic [STATUS_W-1:0]   rstat_q;
	logic                  out_valid_q;
	rsp_word_t             out_word_q;

	logic [CMPW-1:0]       pos_ext;
	logic [CMPW-1:0]       cnt_ext;
	logic [CW-1:0]         pos_c;
	logic [CW-1:0]         half;
	logic                  front;
	logic                  is_full;
	logic [IW-1:0]         slot_pos;
	logic [IW-1:0]         head_dec;
	logic [IW-1:0]         head_inc;
	logic [CW-1:0]         k_src;
	logic [STATUS_W-1:0]   chk_status;
	logic                  accept;
	logic                  load_out;

	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [IW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign pos_ext  = CMPW'(pos_q);
	assign cnt_ext  = CMPW'(count_q);
	assign pos_c    = CW'(pos_q);
	assign half     = count_q >> 1;
	assign front    = pos_c < half;
	assign is_full  = count_q == CW'(CAPACITY);
	assign slot_pos = slot_of(head_q, pos_c);
	assign head_dec = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
	assign head_inc = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
	assign k_src    = up_q ? k_q + CW'(1) : k_q - CW'(1);

	assign accept    = cmd.valid && cmd.ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign cmd.ready = state_q == S_IDLE;
	assign rsp.valid = out_valid_q;
	assign rsp.word  = out_word_q;

	always_comb begin
		chk_status = ST_OK;
		if (op_q == OP_INSERT) begin
			if (is_full) begin
				chk_status = ST_FULL;
			end else if (pos_ext > cnt_ext) begin
				chk_status = ST_RANGE;
			end
		end else if (pos_ext >= cnt_ext) begin
			chk_status = ST_RANGE;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = slot_pos;
		if (state_q == S_CHECK && chk_status == ST_OK && op_q != OP_INSERT) begin
			ram_re = 1'b1;
		end else if (state_q == S_MOVE && n_q != '0) begin
			ram_re    = 1'b1;
			ram_raddr = slot_of(head_q, k_src);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_pos;
		ram_wdata = val_q;
		if (state_q == S_FETCH && op_q == OP_SET) begin
			ram_we = 1'b1;
		end else if (state_q == S_MOVE && wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == S_FINISH && op_q == OP_INSERT) begin
			ram_we = 1'b1;
		end
	end

	icd_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			k_q         <= '0;
			n_q         <= '0;
			up_q        <= 1'b0;
			front_q     <= 1'b0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (chk_status != ST_OK) begin
						state_q <= S_DONE;
					end else if (op_q == OP_INSERT) begin
						if (front) begin
							head_q <= head_dec;
							k_q    <= '0;
							up_q   <= 1'b1;
							n_q    <= pos_c;
						end else begin
							k_q  <= count_q;
							up_q <= 1'b0;
							n_q  <= count_q - pos_c;
						end
						state_q <= S_MOVE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (op_q == OP_REMOVE) begin
						k_q     <= pos_c;
						front_q <= front;
						if (front) begin
							up_q <= 1'b0;
							n_q  <= pos_c;
						end else begin
							up_q <= 1'b1;
							n_q  <= count_q - CW'(1) - pos_c;
						end
						state_q <= S_MOVE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MOVE: begin
					if (n_q != '0) begin
						k_q        <= k_src;
						n_q        <= n_q - CW'(1);
						wr_pend_s1 <= 1'b1;
					end else begin
						wr_pend_s1 <= 1'b0;
						if (!wr_pend_s1) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (op_q == OP_INSERT) begin
						count_q <= count_q + CW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						if (front_q) begin
							head_q <= head_inc;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.word.opcode;
			pos_q <= cmd.word.position;
			val_q <= DATA_WIDTH'(cmd.word.value_in);
		end
		if (state_q == S_CHECK) begin
			rval_q  <= '0;
			rstat_q <= chk_status;
		end
		if (state_q == S_FETCH) begin
			rval_q <= ram_rdata;
		end
		if (state_q == S_MOVE && n_q != '0) begin
			wr_addr_s1 <= slot_of(head_q, k_q);
		end
		if (load_out) begin
			out_word_q.value_out  <= VALUE_W'(rval_q);
			out_word_q.item_count <= COUNT_W'(count_q);
			out_word_q.status     <= rstat_q;
		end
	end

	`ICD_ASSERT_ALWAYS(a_count_bounded, clk, count_q <= CW'(CAPACITY))
	`ICD_ASSERT(a_move_write_in_move, clk, arst_n, wr_pend_s1 |-> state_q == S_MOVE)
	`ICD_ASSERT(a_count_changes_at_finish, clk, arst_n, !$stable(count_q) |-> $past(state_q) == S_FINISH)
	`ICD_ASSERT(a_head_changes_at_ends, clk, arst_n, !$stable(head_q) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_FINISH))
	`ICD_ASSERT(a_accept_starts_check, clk, arst_n, accept |=> state_q == S_CHECK)

endmodule

`default_nettype wire

// ----- src/icd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module icd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
